@@ rtl/rmst_pkg.sv @@
package rmst_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int SIZE_W = 11;
    localparam int POS_W = 10;
    localparam int DATA_W = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
    localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic {
        CMD_UPDATE = 1'b0,
        CMD_QUERY  = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic [POS_W-1:0]         position;
        logic [POS_W-1:0]         range_high;
        logic signed [DATA_W-1:0] new_value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] max_value;
        logic                     range_error;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_U_DOWN,
        ST_U_UP,
        ST_Q_DESC,
        ST_Q_LEFT,
        ST_Q_RIGHT,
        ST_Q_DRAIN,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_INIT,
        OP_U_DOWN,
        OP_U_LEAF,
        OP_U_UP,
        OP_Q_DESC,
        OP_Q_LEFT,
        OP_Q_RIGHT,
        OP_EMIT
    } op_t;

    typedef struct packed {
        logic clear_last;
        logic bad;
        logic is_query;
        logic leaf;
        logic at_root;
        logic q_full;
        logic q_split;
        logic lo_match;
        logic hi_match;
        logic out_free;
    } stat_t;

    function automatic logic signed [DATA_W-1:0] larger(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        return (a >= b) ? a : b;
    endfunction

endpackage

@@ rtl/rmst_ctrl.sv @@
module rmst_ctrl
    import rmst_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_stall,
    input  stat_t st,
    output op_t   op
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (st.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (st.bad)
                begin
                    state_next = st.is_query ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    state_next = st.is_query ? ST_Q_DESC : ST_U_DOWN;
                end
            end
            ST_U_DOWN:
            begin
                if (st.leaf)
                begin
                    state_next = st.at_root ? ST_IDLE : ST_U_UP;
                end
            end
            ST_U_UP:
            begin
                if (st.at_root)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_Q_DESC:
            begin
                if (st.q_full)
                begin
                    state_next = ST_Q_DRAIN;
                end
                else if (st.q_split)
                begin
                    state_next = ST_Q_LEFT;
                end
            end
            ST_Q_LEFT:
            begin
                if (st.lo_match)
                begin
                    state_next = ST_Q_RIGHT;
                end
            end
            ST_Q_RIGHT:
            begin
                if (st.hi_match)
                begin
                    state_next = ST_Q_DRAIN;
                end
            end
            ST_Q_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op = OP_NONE;
        req_stall = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                op = OP_CLEAR;
            end
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    op = OP_LOAD;
                end
            end
            ST_CHECK:
            begin
                op = OP_INIT;
            end
            ST_U_DOWN:
            begin
                op = st.leaf ? OP_U_LEAF : OP_U_DOWN;
            end
            ST_U_UP:
            begin
                op = OP_U_UP;
            end
            ST_Q_DESC:
            begin
                op = OP_Q_DESC;
            end
            ST_Q_LEFT:
            begin
                op = OP_Q_LEFT;
            end
            ST_Q_RIGHT:
            begin
                op = OP_Q_RIGHT;
            end
            ST_Q_DRAIN:
            begin
                op = OP_NONE;
            end
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    op = OP_EMIT;
                end
            end
            default:
            begin
                op = OP_NONE;
            end
        endcase
    end

`ifndef SYNTH
    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && req_valid) |=> (state_reg == ST_CHECK))
        else $error("accepted transaction did not move to the range check");

    a_drain_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_Q_DRAIN) |=> (state_reg == ST_EMIT))
        else $error("query drain was not followed by the result stage");

    a_stall_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> req_stall)
        else $error("input not stalled while a transaction is being worked");
`endif

endmodule

@@ rtl/rmst_dp.sv @@
module rmst_dp
    import rmst_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  op_t               op,
    output stat_t             st,
    input  req_t              req,
    input  logic              size_we,
    input  logic [SIZE_W-1:0] size_wdata,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rsp_t              rsp
);

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int NODE_W = IDX_W + 1;
    localparam int DEPTH = 2 ** NODE_W;
    localparam int CMP_W = (SIZE_W > NODE_W) ? SIZE_W : NODE_W;

    logic signed [DATA_W-1:0] node_mem [DEPTH];

    logic [SIZE_W-1:0]        size_reg;
    req_t                     item_reg;
    req_t                     item_next;
    logic [NODE_W-1:0]        clr_cnt_reg;
    logic [NODE_W-1:0]        clr_cnt_next;
    logic [NODE_W-1:0]        k_reg;
    logic [NODE_W-1:0]        k_next;
    logic [IDX_W-1:0]         s_reg;
    logic [IDX_W-1:0]         s_next;
    logic [IDX_W-1:0]         e_reg;
    logic [IDX_W-1:0]         e_next;
    logic [IDX_W-1:0]         lo_reg;
    logic [IDX_W-1:0]         lo_next;
    logic [IDX_W-1:0]         hi_reg;
    logic [IDX_W-1:0]         hi_next;
    logic [NODE_W-1:0]        rk_reg;
    logic [NODE_W-1:0]        rk_next;
    logic [IDX_W-1:0]         rs_reg;
    logic [IDX_W-1:0]         rs_next;
    logic [IDX_W-1:0]         re_reg;
    logic [IDX_W-1:0]         re_next;
    logic signed [DATA_W-1:0] acc_reg;
    logic signed [DATA_W-1:0] acc_next;
    logic signed [DATA_W-1:0] cur_reg;
    logic signed [DATA_W-1:0] cur_next;
    logic                     pend_reg;
    logic                     pend_next;
    logic signed [DATA_W-1:0] rd_data_reg;
    rsp_t                     rsp_reg;
    rsp_t                     rsp_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;

    logic                     wr_en;
    logic [NODE_W-1:0]        wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic                     rd_en;
    logic [NODE_W-1:0]        rd_addr;

    logic [CMP_W-1:0]         pos_cmp;
    logic [CMP_W-1:0]         high_cmp;
    logic [CMP_W-1:0]         size_cmp;
    logic [CMP_W-1:0]         cap_cmp;
    logic [CMP_W-1:0]         n_cmp;
    logic [CMP_W-1:0]         n_m1;
    logic                     bad_query;
    logic                     bad_update;
    logic                     is_query;
    logic [IDX_W:0]           sum_se;
    logic [IDX_W-1:0]         mid;
    logic [IDX_W-1:0]         mid_p1;
    logic [NODE_W-1:0]        child_l;
    logic [NODE_W-1:0]        child_r;
    logic [NODE_W-1:0]        sibling;
    logic [NODE_W-1:0]        k_m1;
    logic [NODE_W-1:0]        parent;
    logic signed [DATA_W-1:0] acc_base;
    logic signed [DATA_W-1:0] up_val;

    assign pos_cmp    = CMP_W'(item_reg.position);
    assign high_cmp   = CMP_W'(item_reg.range_high);
    assign size_cmp   = CMP_W'(size_reg);
    assign cap_cmp    = CMP_W'(MAX_ELEMENTS);
    assign n_cmp      = (size_cmp > cap_cmp) ? cap_cmp : size_cmp;
    assign n_m1       = n_cmp - CMP_W'(1);
    assign bad_query  = (pos_cmp > high_cmp) || (high_cmp >= n_cmp);
    assign bad_update = (pos_cmp >= n_cmp);
    assign is_query   = (item_reg.cmd == CMD_QUERY);

    assign sum_se  = {1'b0, s_reg} + {1'b0, e_reg};
    assign mid     = sum_se[IDX_W:1];
    assign mid_p1  = mid + IDX_W'(1);
    assign child_l = {k_reg[NODE_W-2:0], 1'b1};
    assign child_r = child_l + NODE_W'(1);
    assign sibling = k_reg[0] ? (k_reg + NODE_W'(1)) : (k_reg - NODE_W'(1));
    assign k_m1    = k_reg - NODE_W'(1);
    assign parent  = {1'b0, k_m1[NODE_W-1:1]};

    assign acc_base = pend_reg ? larger(acc_reg, rd_data_reg) : acc_reg;
    assign up_val   = larger(cur_reg, rd_data_reg);

    assign st.clear_last = (clr_cnt_reg == {NODE_W{1'b1}});
    assign st.bad        = is_query ? bad_query : bad_update;
    assign st.is_query   = is_query;
    assign st.leaf       = (s_reg == e_reg);
    assign st.at_root    = (k_reg == '0);
    assign st.q_full     = (lo_reg == s_reg) && (hi_reg == e_reg);
    assign st.q_split    = (hi_reg > mid) && (lo_reg <= mid);
    assign st.lo_match   = (lo_reg == s_reg);
    assign st.hi_match   = (hi_reg == e_reg);
    assign st.out_free   = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        item_next      = item_reg;
        clr_cnt_next   = clr_cnt_reg;
        k_next         = k_reg;
        s_next         = s_reg;
        e_next         = e_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        rk_next        = rk_reg;
        rs_next        = rs_reg;
        re_next        = re_reg;
        acc_next       = acc_base;
        cur_next       = cur_reg;
        pend_next      = 1'b0;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        wr_en          = 1'b0;
        wr_addr        = k_reg;
        wr_data        = cur_reg;
        rd_en          = 1'b0;
        rd_addr        = k_reg;

        unique case (op)
            OP_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = INT_MIN;
                clr_cnt_next = clr_cnt_reg + NODE_W'(1);
            end
            OP_LOAD:
            begin
                item_next = req;
            end
            OP_INIT:
            begin
                k_next   = '0;
                s_next   = '0;
                e_next   = n_m1[IDX_W-1:0];
                lo_next  = pos_cmp[IDX_W-1:0];
                hi_next  = high_cmp[IDX_W-1:0];
                acc_next = INT_MIN;
            end
            OP_U_DOWN:
            begin
                if (lo_reg <= mid)
                begin
                    k_next = child_l;
                    e_next = mid;
                end
                else
                begin
                    k_next = child_r;
                    s_next = mid_p1;
                end
            end
            OP_U_LEAF:
            begin
                wr_en    = 1'b1;
                wr_data  = item_reg.new_value;
                cur_next = item_reg.new_value;
                rd_en    = !st.at_root;
                rd_addr  = sibling;
                k_next   = parent;
            end
            OP_U_UP:
            begin
                wr_en    = 1'b1;
                wr_data  = up_val;
                cur_next = up_val;
                rd_en    = !st.at_root;
                rd_addr  = sibling;
                k_next   = parent;
            end
            OP_Q_DESC:
            begin
                if (st.q_full)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                end
                else if (hi_reg <= mid)
                begin
                    k_next = child_l;
                    e_next = mid;
                end
                else if (lo_reg > mid)
                begin
                    k_next = child_r;
                    s_next = mid_p1;
                end
                else
                begin
                    rk_next = child_r;
                    rs_next = mid_p1;
                    re_next = e_reg;
                    k_next  = child_l;
                    e_next  = mid;
                end
            end
            OP_Q_LEFT:
            begin
                if (st.lo_match)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    k_next    = rk_reg;
                    s_next    = rs_reg;
                    e_next    = re_reg;
                end
                else if (lo_reg > mid)
                begin
                    k_next = child_r;
                    s_next = mid_p1;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = child_r;
                    pend_next = 1'b1;
                    k_next    = child_l;
                    e_next    = mid;
                end
            end
            OP_Q_RIGHT:
            begin
                if (st.hi_match)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                end
                else if (hi_reg <= mid)
                begin
                    k_next = child_l;
                    e_next = mid;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = child_l;
                    pend_next = 1'b1;
                    k_next    = child_r;
                    s_next    = mid_p1;
                end
            end
            OP_EMIT:
            begin
                rsp_next.max_value   = acc_reg;
                rsp_next.range_error = st.bad;
                rsp_valid_next       = 1'b1;
            end
            default:
            begin
                rsp_next = rsp_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= node_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SIZE_RESET;
            clr_cnt_reg   <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (size_we)
            begin
                size_reg <= size_wdata;
            end
            clr_cnt_reg   <= clr_cnt_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        k_reg    <= k_next;
        s_reg    <= s_next;
        e_reg    <= e_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        rk_reg   <= rk_next;
        rs_reg   <= rs_next;
        re_reg   <= re_next;
        acc_reg  <= acc_next;
        cur_reg  <= cur_next;
        rsp_reg  <= rsp_next;
    end

`ifndef SYNTH
    a_query_in_node: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_Q_DESC) |-> (s_reg <= lo_reg && lo_reg <= hi_reg && hi_reg <= e_reg))
        else $error("query range left the span of the current node");

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_EMIT) |-> (!rsp_valid_reg || !rsp_stall))
        else $error("result written over a transaction still waiting");

    a_sibling_read: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_U_UP) |-> $past(rd_en))
        else $error("ancestor refresh without a sibling read in the cycle before");
`endif

endmodule

@@ rtl/range_max_segment_tree.sv @@
// Update: one node step per cycle down to the leaf, then one ancestor write per cycle back up.
// Query: the result is the largest of the node values read from the node memory.
// One transaction at a time; the next is accepted once the controller is back in idle,
// even while a result waits.
// After reset a clearing pass writes every node to the most negative value, and no
// transaction is accepted until it ends.
module range_max_segment_tree
    import rmst_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  req_t              req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rsp_t              rsp,
    input  logic              size_we,
    input  logic [SIZE_W-1:0] size_wdata
);

    op_t   op;
    stat_t st;

    rmst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .st        (st),
        .op        (op)
    );

    rmst_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .st         (st),
        .req        (req),
        .size_we    (size_we),
        .size_wdata (size_wdata),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule
